// File: rtl/core/assert_macros.svh
// Assertion macros shared by the capture unit RTL.
// Depends on nothing; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Expression must never be true out of reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

// File: rtl/core/dcap_pkg.sv
`timescale 1ns / 1ps
// Types, constants and codes of the button press capture unit.
// No dependencies; imported by every module of the block.
package dcap_pkg;

    localparam int NUM_DEVICES = 8;
    localparam int NUM_BUTTONS = 128;
    localparam int BUTTON_BITS = 128;          // fixed width of one snapshot
    localparam int DEV_W       = 3;
    localparam int BTN_W       = 7;
    localparam int LANE_W      = 16;
    localparam int NUM_LANES   = BUTTON_BITS / LANE_W;
    localparam int LANE_IDX_W  = $clog2(LANE_W);
    localparam int LANE_SEL_W  = $clog2(NUM_LANES);
    localparam int OUT_DEPTH   = 2;
    localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

    // Buttons above NUM_BUTTONS are masked off.
    localparam logic [BUTTON_BITS-1:0] BTN_MASK =
        {BUTTON_BITS{1'b1}} >> (BUTTON_BITS - NUM_BUTTONS);

    // Item modes
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_SNAP  = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    // Register indexes
    localparam logic [1:0] REG_DEVICE_COUNT    = 2'd0;
    localparam logic [1:0] REG_DEBOUNCE_FRAMES = 2'd1;
    localparam logic [1:0] REG_TIMEOUT_TICKS   = 2'd2;

    localparam logic [3:0]  DEVICE_COUNT_RST = 4'd0;
    localparam logic [3:0]  DEBOUNCE_RST     = 4'd2;
    localparam logic [15:0] TIMEOUT_RST      = 16'd8000;
    localparam logic [15:0] ELAPSED_MAX      = 16'hFFFF;
    localparam logic [3:0]  CAND_CNT_MAX     = 4'hF;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_STARTED   = 3'd1,
        ST_REJECTED  = 3'd2,
        ST_CAPTURING = 3'd3,
        ST_CAPTURED  = 3'd4,
        ST_TIMED_OUT = 3'd5
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [2:0]  bound_device;
        logic [7:0]  bound_button;
    } t_result;

    // What one lane found in its slice of the snapshot
    typedef struct packed {
        logic                  found;
        logic [LANE_IDX_W-1:0] idx;
        logic                  held;
    } t_lane_res;

    // Merged view over all lanes
    typedef struct packed {
        logic             found;
        logic [BTN_W-1:0] button;
        logic             held;
    } t_hit;

endpackage

// File: rtl/core/dcap_intf.sv
`timescale 1ns / 1ps
// Channel interfaces of the capture unit: input items, results, register writes.
// Depends on nothing but plain logic types.
interface dcap_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [2:0]  device;
    logic        snapshot_ok;
    logic [63:0] buttons_low;
    logic [63:0] buttons_high;
    logic        frame_end;

    modport source (output valid, mode, device, snapshot_ok, buttons_low, buttons_high,
                    frame_end, input ready);
    modport sink   (input valid, mode, device, snapshot_ok, buttons_low, buttons_high,
                    frame_end, output ready);
endinterface

interface dcap_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [2:0] bound_device;
    logic [7:0] bound_button;

    modport source (output valid, status, bound_device, bound_button, input ready);
    modport sink   (input valid, status, bound_device, bound_button, output ready);
endinterface

interface dcap_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/dcap_lane.sv
`timescale 1ns / 1ps
// One lane: edge detect and lowest-set priority encode over a slice of buttons.
// Depends on dcap_pkg.
module dcap_lane
    import dcap_pkg::*;
(
    input  logic [LANE_W-1:0]     i_new,
    input  logic [LANE_W-1:0]     i_old,
    input  logic [LANE_IDX_W-1:0] i_sel,
    output t_lane_res             o_res
);

    logic [LANE_W-1:0] rise;

    assign rise = i_new & ~i_old;

    always_comb begin
        o_res.found = |rise;
        o_res.idx   = '0;
        // walk down so the lowest set bit wins
        for (int b = LANE_W - 1; b >= 0; b--) begin
            if (rise[b]) begin
                o_res.idx = LANE_IDX_W'(b);
            end
        end
        o_res.held = i_new[i_sel];
    end

endmodule

// File: rtl/core/dcap_merge.sv
`timescale 1ns / 1ps
// Merge stage: lowest lane with a rising edge wins; held bit taken from the
// candidate's lane. Depends on dcap_pkg.
module dcap_merge
    import dcap_pkg::*;
(
    input  t_lane_res             i_lanes [NUM_LANES],
    input  logic [LANE_SEL_W-1:0] i_cand_lane,
    output t_hit                  o_hit
);

    always_comb begin
        o_hit.found  = 1'b0;
        o_hit.button = '0;
        for (int l = NUM_LANES - 1; l >= 0; l--) begin
            if (i_lanes[l].found) begin
                o_hit.found  = 1'b1;
                o_hit.button = BTN_W'(l * LANE_W) + BTN_W'(i_lanes[l].idx);
            end
        end
        o_hit.held = i_lanes[i_cand_lane].held;
    end

endmodule

// File: rtl/core/dcap_out_fifo.sv
`timescale 1ns / 1ps
// Two-entry result queue between the core and the output channel.
// Depends on dcap_pkg and assert_macros.svh.
`include "assert_macros.svh"
module dcap_out_fifo
    import dcap_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    t_result              r_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wr_ptr;
    logic [OUT_PTR_W-1:0] r_rd_ptr;
    logic [OUT_CNT_W-1:0] r_count;
    logic                 pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == OUT_CNT_W'(OUT_DEPTH));
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + OUT_CNT_W'(i_push) - OUT_CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    `ASSERT_NEVER(a_fifo_overrun, i_clk, i_rst_n, i_push && o_full)
    `ASSERT_PROP(a_fifo_count_range, i_clk, i_rst_n, r_count <= OUT_CNT_W'(OUT_DEPTH))

endmodule

// File: rtl/core/debounced_button_press_capture_unit.sv
`timescale 1ns / 1ps
// Top level of the debounced button press capture unit.
// Depends on dcap_pkg, dcap_intf, dcap_lane, dcap_merge, dcap_out_fifo, assert_macros.svh.
//
// Usage:
//  i_item  : valid/ready channel of items. mode 0 arms capture, mode 1 carries one
//            controller snapshot of 128 button bits (frame_end on the last of a
//            poll frame), mode 2 is a time tick.
//  o_result: valid/ready channel of results (status, bound device, bound button).
//            A start and every frame-end snapshot give one result; others none.
//  i_cfg   : register writes (device count, debounce frames, timeout ticks),
//            always ready; write only while no item is in flight.
// Result  : a result sits in the output queue in the cycle after its item is taken.
// Throughput: one item per cycle while the result queue is not full. All per-item
//            work (snapshot edge detect over eight 16-bit lanes, lane merge and
//            candidate update) completes in the accepting cycle.
// Stall   : a two-entry result queue decouples the sides; i_item.ready drops
//            only when the queue is full, and nothing is lost.
// Reset   : synchronous, active low. Capture is disarmed, stored snapshots read
//            as all released, registers return to their defaults.
`include "assert_macros.svh"
module debounced_button_press_capture_unit
    import dcap_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    dcap_in_if.sink    i_item,
    dcap_out_if.source o_result,
    dcap_cfg_if.sink   i_cfg
);

    // configuration
    logic [3:0]  r_dev_count;
    logic [3:0]  r_debounce;
    logic [15:0] r_timeout;

    // last good snapshot per controller
    logic [BUTTON_BITS-1:0] r_last [NUM_DEVICES];

    // capture state
    logic             r_active,     n_active;
    logic             r_cand_pres,  n_cand_pres;
    logic [DEV_W-1:0] r_cand_dev,   n_cand_dev;
    logic [BTN_W-1:0] r_cand_btn,   n_cand_btn;
    logic [3:0]       r_cand_cnt,   n_cand_cnt;
    logic [15:0]      r_elapsed,    n_elapsed;
    // per-frame accumulators
    logic             r_held_now,   n_held_now;
    logic             r_edge_found, n_edge_found;
    logic [DEV_W-1:0] r_edge_dev,   n_edge_dev;
    logic [BTN_W-1:0] r_edge_btn,   n_edge_btn;

    logic                   accept;
    logic                   full;
    logic                   push;
    t_result                res;
    logic                   snap_take;
    logic [BUTTON_BITS-1:0] new_bits;
    logic [BUTTON_BITS-1:0] old_bits;
    t_lane_res              lane_res [NUM_LANES];
    t_hit                   hit;
    t_result                fifo_q;

    assign accept       = i_item.valid && i_item.ready;
    assign i_item.ready = !full;
    assign i_cfg.ready  = 1'b1;

    assign new_bits  = {i_item.buttons_high, i_item.buttons_low} & BTN_MASK;
    assign old_bits  = r_last[i_item.device];
    assign snap_take = (i_item.mode == MODE_SNAP) && i_item.snapshot_ok
                       && ({1'b0, i_item.device} < r_dev_count);

    // lanes: each takes a 16-button slice of the snapshot
    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        dcap_lane u_lane (
            .i_new (new_bits[l*LANE_W +: LANE_W]),
            .i_old (old_bits[l*LANE_W +: LANE_W]),
            .i_sel (r_cand_btn[LANE_IDX_W-1:0]),
            .o_res (lane_res[l])
        );
    end

    dcap_merge u_merge (
        .i_lanes     (lane_res),
        .i_cand_lane (r_cand_btn[BTN_W-1:LANE_IDX_W]),
        .o_hit       (hit)
    );

    // next-state and result
    always_comb begin
        logic [3:0] cnt_inc;
        logic       upd_edge;

        n_active     = r_active;
        n_cand_pres  = r_cand_pres;
        n_cand_dev   = r_cand_dev;
        n_cand_btn   = r_cand_btn;
        n_cand_cnt   = r_cand_cnt;
        n_elapsed    = r_elapsed;
        n_held_now   = r_held_now;
        n_edge_found = r_edge_found;
        n_edge_dev   = r_edge_dev;
        n_edge_btn   = r_edge_btn;
        push         = 1'b0;
        res          = '{status: ST_IDLE, bound_device: '0, bound_button: '0};
        cnt_inc      = (r_cand_cnt == CAND_CNT_MAX) ? r_cand_cnt : r_cand_cnt + 4'd1;
        upd_edge     = 1'b0;

        if (accept) begin
            case (i_item.mode)
                MODE_START: begin
                    push = 1'b1;
                    if (r_dev_count == '0) begin
                        res.status = ST_REJECTED;   // armed state left as it was
                    end else begin
                        res.status   = ST_STARTED;
                        n_active     = 1'b1;
                        n_elapsed    = '0;
                        n_cand_pres  = 1'b0;
                        n_cand_dev   = '0;
                        n_cand_btn   = '0;
                        n_cand_cnt   = '0;
                        n_held_now   = 1'b0;
                        n_edge_found = 1'b0;
                        n_edge_dev   = '0;
                        n_edge_btn   = '0;
                    end
                end
                MODE_TICK: begin
                    if (r_active && (r_elapsed != ELAPSED_MAX)) begin
                        n_elapsed = r_elapsed + 16'd1;
                    end
                end
                MODE_SNAP: begin
                    // fold this snapshot into the frame accumulators
                    if (snap_take && r_cand_pres && (r_cand_dev == i_item.device)) begin
                        n_held_now = hit.held;
                    end
                    upd_edge = snap_take && hit.found
                               && (!r_edge_found || (i_item.device < r_edge_dev));
                    if (upd_edge) begin
                        n_edge_found = 1'b1;
                        n_edge_dev   = i_item.device;
                        n_edge_btn   = hit.button;
                    end

                    if (i_item.frame_end) begin
                        push = 1'b1;
                        if (!r_active) begin
                            res.status = ST_IDLE;
                        end else if (r_cand_pres && n_held_now && (cnt_inc >= r_debounce)) begin
                            // candidate held long enough: bound
                            res.status       = ST_CAPTURED;
                            res.bound_device = r_cand_dev;
                            res.bound_button = {1'b0, r_cand_btn} + 8'd1;
                            n_active         = 1'b0;
                            n_cand_pres      = 1'b0;
                            n_cand_dev       = '0;
                            n_cand_btn       = '0;
                            n_cand_cnt       = '0;
                        end else begin
                            if (r_cand_pres && n_held_now) begin
                                n_cand_cnt = cnt_inc;
                            end else if (n_edge_found) begin
                                // no candidate or a released one: this frame's edge takes over
                                n_cand_pres = 1'b1;
                                n_cand_dev  = n_edge_dev;
                                n_cand_btn  = n_edge_btn;
                                n_cand_cnt  = 4'd1;
                            end else begin
                                // released candidate dropped, nothing new to take
                                n_cand_pres = 1'b0;
                                n_cand_dev  = '0;
                                n_cand_btn  = '0;
                                n_cand_cnt  = '0;
                            end
                            if (r_elapsed >= r_timeout) begin
                                res.status  = ST_TIMED_OUT;
                                n_active    = 1'b0;
                                n_cand_pres = 1'b0;
                                n_cand_dev  = '0;
                                n_cand_btn  = '0;
                                n_cand_cnt  = '0;
                            end else begin
                                res.status = ST_CAPTURING;
                            end
                        end
                        // every frame end starts the accumulators afresh
                        n_held_now   = 1'b0;
                        n_edge_found = 1'b0;
                        n_edge_dev   = '0;
                        n_edge_btn   = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_count  <= DEVICE_COUNT_RST;
            r_debounce   <= DEBOUNCE_RST;
            r_timeout    <= TIMEOUT_RST;
            r_active     <= 1'b0;
            r_cand_pres  <= 1'b0;
            r_cand_dev   <= '0;
            r_cand_btn   <= '0;
            r_cand_cnt   <= '0;
            r_elapsed    <= '0;
            r_held_now   <= 1'b0;
            r_edge_found <= 1'b0;
            r_edge_dev   <= '0;
            r_edge_btn   <= '0;
            for (int d = 0; d < NUM_DEVICES; d++) begin
                r_last[d] <= '0;
            end
        end else begin
            r_active     <= n_active;
            r_cand_pres  <= n_cand_pres;
            r_cand_dev   <= n_cand_dev;
            r_cand_btn   <= n_cand_btn;
            r_cand_cnt   <= n_cand_cnt;
            r_elapsed    <= n_elapsed;
            r_held_now   <= n_held_now;
            r_edge_found <= n_edge_found;
            r_edge_dev   <= n_edge_dev;
            r_edge_btn   <= n_edge_btn;
            if (accept && snap_take) begin
                r_last[i_item.device] <= new_bits;
            end
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_DEVICE_COUNT:    r_dev_count <= i_cfg.data[3:0];
                    REG_DEBOUNCE_FRAMES: r_debounce  <= i_cfg.data[3:0];
                    REG_TIMEOUT_TICKS:   r_timeout   <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
        end
    end

    dcap_out_fifo u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (res),
        .o_full  (full),
        .o_valid (o_result.valid),
        .i_ready (o_result.ready),
        .o_data  (fifo_q)
    );

    assign o_result.status       = fifo_q.status;
    assign o_result.bound_device = fifo_q.bound_device;
    assign o_result.bound_button = fifo_q.bound_button;

    `ASSERT_PROP(a_cand_cnt_nonzero, i_clk, i_rst_n, !r_cand_pres || (r_cand_cnt != 4'd0))
    `ASSERT_PROP(a_capture_disarms, i_clk, i_rst_n, (push && (res.status == ST_CAPTURED)) |=> !r_active)
    `ASSERT_PROP(a_start_arms, i_clk, i_rst_n, (push && (res.status == ST_STARTED)) |=> (r_active && (r_elapsed == 16'd0)))

endmodule
